@@ hdl/bfpa_pkg.sv @@
// Shared types and constants for the best-fit pool allocator.
// No dependencies.
package bfpa_pkg;
  localparam int MAX_SEGMENTS = 64;
  localparam int ALIGN_BYTES  = 512;
  localparam int SEG_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ALIGN_W      = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
  localparam logic [31:0] POOL_RESET = 32'd1048576;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam logic [1:0] ST_IDLESEG = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] request_size;
    logic [31:0] free_offset;
  } bfpa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] used_bytes;
    logic [31:0] peak_bytes;
  } bfpa_rsp_t;

  function automatic logic [31:0] align_down(input logic [31:0] v);
    return (v / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction
endpackage

@@ hdl/best_fit_pool_allocator_top.sv @@
// Best-fit pool allocator: request in, one response out.
// One request at a time; the next is accepted only once the response has left and no pool_size write is pending.
// Reset (rst_n low, synchronous) or a pool_size write rebuilds one idle segment.
// Depends on bfpa_pkg.
module best_fit_pool_allocator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bfpa_pkg::bfpa_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bfpa_pkg::bfpa_rsp_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import bfpa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_AGRNT = 4'd2;
  localparam logic [3:0] S_FNEXT = 4'd3;
  localparam logic [3:0] S_FPREV = 4'd4;
  localparam logic [3:0] S_FFIN  = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;
  localparam logic [3:0] S_RDSET = 4'd7;

  logic [31:0] off_mem [MAX_SEGMENTS];
  logic [31:0] len_mem [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] use_r, vld_r;

  logic [3:0]       state_r;
  logic [CNT_W-1:0] idx_r;
  bfpa_req_t        req_r;
  logic [32:0]      need_r;
  logic             found_r, slot_ok_r;
  logic [SEG_W-1:0] best_r, slot_r, nx_r;
  logic [31:0]      best_len_r, best_off_r, cur_off_r, cur_len_r;
  logic             nx_ok_r;
  logic [31:0]      nx_len_r;
  logic [31:0]      used_r, peak_r;
  logic             out_valid_r;
  bfpa_rsp_t        out_r;
  logic [31:0]      rd_off_r, rd_len_r;
  logic [SEG_W-1:0] rd_idx_r;

  wire [SEG_W-1:0] idx = idx_r[SEG_W-1:0];
  wire scan_end = (idx_r == CNT_W'(MAX_SEGMENTS));

  assign in_stall  = (state_r != S_IDLE) || out_valid_r || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // synchronous read port, addressed by the walk index
  always_ff @(posedge clk) begin
    rd_off_r <= off_mem[idx];
    rd_len_r <= len_mem[idx];
    rd_idx_r <= idx;
  end

  logic [32:0] need_c;
  always_comb begin
    need_c = ({1'b0, in_data.request_size} + 33'(ALIGN_BYTES - 1)) / ALIGN_BYTES * ALIGN_BYTES;
    if (in_data.request_size == 32'd0) need_c = 33'(ALIGN_BYTES);
  end

  wire rv  = vld_r[rd_idx_r];
  wire ru  = use_r[rd_idx_r];
  wire [32:0] rem_c = {1'b0, best_len_r} - need_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      use_r       <= '0;
      vld_r       <= MAX_SEGMENTS'(1);
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      off_mem[0]  <= '0;
      len_mem[0]  <= align_down(POOL_RESET);
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            use_r      <= '0;
            vld_r      <= MAX_SEGMENTS'(1);
            used_r     <= '0;
            peak_r     <= '0;
            off_mem[0] <= '0;
            len_mem[0] <= align_down(cfg_data);
          end else if (in_valid && !in_stall) begin
            req_r     <= in_data;
            need_r    <= need_c;
            found_r   <= 1'b0;
            slot_ok_r <= 1'b0;
            nx_ok_r   <= 1'b0;
            idx_r     <= '0;
            state_r   <= S_RDSET;
          end
        end
        S_RDSET: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // rd_* holds entry rd_idx_r
          if (req_r.op == OP_ALLOC) begin
            if (rv && !ru && {1'b0, rd_len_r} >= need_r &&
                (!found_r || rd_len_r < best_len_r ||
                 (rd_len_r == best_len_r && rd_off_r < best_off_r))) begin
              found_r <= 1'b1; best_r <= rd_idx_r;
              best_len_r <= rd_len_r; best_off_r <= rd_off_r;
            end
          end else if (rv && rd_off_r == req_r.free_offset && !found_r) begin
            found_r <= 1'b1; best_r <= rd_idx_r;
            best_len_r <= rd_len_r; best_off_r <= rd_off_r;
          end
          if (!rv && !slot_ok_r) begin
            slot_ok_r <= 1'b1; slot_r <= rd_idx_r;
          end
          if (rd_idx_r == SEG_W'(MAX_SEGMENTS - 1)) begin
            idx_r   <= '0;
            state_r <= (req_r.op == OP_ALLOC) ? S_AGRNT : S_FNEXT;
          end else if (!scan_end) idx_r <= idx_r + 1'b1;
        end
        S_AGRNT: begin
          out_r.granted_offset <= '0;
          if (!found_r) begin
            out_r.status <= ST_NOFIT;
            out_r.used_bytes <= used_r; out_r.peak_bytes <= peak_r;
          end else begin
            logic [31:0] g, u;
            g = best_len_r;
            if (rem_c >= 33'(ALIGN_BYTES) && slot_ok_r) begin
              g = need_r[31:0];
              len_mem[best_r] <= need_r[31:0];
              off_mem[slot_r] <= best_off_r + need_r[31:0];
              len_mem[slot_r] <= rem_c[31:0];
              use_r[slot_r]   <= 1'b0;
              vld_r[slot_r]   <= 1'b1;
            end
            u = used_r + g;
            use_r[best_r] <= 1'b1;
            used_r <= u;
            if (u > peak_r) peak_r <= u;
            out_r.status <= ST_OK;
            out_r.granted_offset <= best_off_r;
            out_r.used_bytes <= u;
            out_r.peak_bytes <= (u > peak_r) ? u : peak_r;
          end
          state_r <= S_OUT;
        end
        S_FNEXT: begin
          if (!found_r || !use_r[best_r]) begin
            out_r.status <= found_r ? ST_IDLESEG : ST_NOTFND;
            out_r.granted_offset <= '0;
            out_r.used_bytes <= used_r; out_r.peak_bytes <= peak_r;
            state_r <= S_OUT;
          end else begin
            use_r[best_r] <= 1'b0;
            used_r <= used_r - best_len_r;
            cur_off_r <= best_off_r + best_len_r;
            nx_ok_r <= 1'b0;
            idx_r <= '0;
            state_r <= S_FPREV;
            found_r <= 1'b0;
          end
        end
        S_FPREV: begin
          // pass 1 (found_r=0): locate successor and merge it; pass 2: find predecessor for S_FFIN to merge
          if (!found_r) begin
            if (idx_r != '0 && rv && rd_off_r == cur_off_r && !nx_ok_r) begin
              nx_ok_r <= 1'b1; nx_r <= rd_idx_r; nx_len_r <= rd_len_r;
            end
            if (idx_r == CNT_W'(MAX_SEGMENTS)) begin
              if (nx_ok_r || (rv && rd_off_r == cur_off_r)) begin
                logic [SEG_W-1:0] n; logic [31:0] nl;
                n  = nx_ok_r ? nx_r : rd_idx_r;
                nl = nx_ok_r ? nx_len_r : rd_len_r;
                if (n != best_r && !use_r[n]) begin
                  len_mem[best_r] <= best_len_r + nl;
                  best_len_r <= best_len_r + nl;
                  vld_r[n] <= 1'b0;
                end
              end
              nx_ok_r <= 1'b0; found_r <= 1'b1; idx_r <= '0;
            end else idx_r <= idx_r + 1'b1;
          end else begin
            if (idx_r != '0 && rd_idx_r != best_r && rv &&
                rd_off_r + rd_len_r == best_off_r && !nx_ok_r) begin
              nx_ok_r <= 1'b1; nx_r <= rd_idx_r; nx_len_r <= rd_len_r;
            end
            if (idx_r == CNT_W'(MAX_SEGMENTS)) begin
              cur_len_r <= best_len_r;
              if (!nx_ok_r && rd_idx_r != best_r && rv &&
                  rd_off_r + rd_len_r == best_off_r) begin
                nx_ok_r <= 1'b1; nx_r <= rd_idx_r; nx_len_r <= rd_len_r;
              end
              state_r <= S_FFIN;
            end else idx_r <= idx_r + 1'b1;
          end
        end
        S_FFIN: begin
          if (nx_ok_r && !use_r[nx_r]) begin
            len_mem[nx_r] <= nx_len_r + cur_len_r;
            vld_r[best_r] <= 1'b0;
          end
          out_r.status <= ST_OK;
          out_r.granted_offset <= '0;
          out_r.used_bytes <= used_r; out_r.peak_bytes <= peak_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          idx_r <= '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("stray response");
  a_peak_ge_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.peak_bytes >= out_r.used_bytes || out_r.status != ST_OK
    || req_r.op == OP_FREE) else $error("peak below used");
  a_seg0_or_any: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> vld_r != '0) else $error("table empty");
`endif
endmodule
